>>> src/mono_lcd_page_framebuffer_engine_core_defines.svh
// Assertion macros shared by the framebuffer engine checker.
`ifndef MONO_LCD_PAGE_FRAMEBUFFER_ENGINE_CORE_DEFINES_SVH
`define MONO_LCD_PAGE_FRAMEBUFFER_ENGINE_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define MLCD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Signal must hold its value over a cycle in which the trigger is true.
`define MLCD_ASSERT_STABLE(name, trig, sig) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> $stable(sig)) \
    else $error("%m: signal changed while stalled");

`endif

>>> src/mlcd_pkg.sv
// Package: types, codes and defaults of the page framebuffer engine.
`timescale 1ns / 1ps
package mlcd_pkg;

  localparam int ScreenColumns = 128;
  localparam int ScreenPages   = 8;
  localparam int ByteW         = 8;
  localparam int ActionW       = 3;

  localparam logic [ByteW-1:0] InvertMask = 8'hFF;

  typedef enum logic [ActionW-1:0] {
    ACT_SET    = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_TOGGLE = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_INVERT = 3'd4,
    ACT_FILL   = 3'd5,
    ACT_READ   = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ALU_KEEP,
    ALU_SET,
    ALU_CLR,
    ALU_TGL,
    ALU_LOAD,
    ALU_INV
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [2:0]       bit_idx;
    logic [ByteW-1:0] data;
  } alu_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_INV_RD,
    ST_INV_WR,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

>>> src/mlcd_chan_if.sv
// Channel interfaces: command items in, result items out.
`timescale 1ns / 1ps
interface mlcd_in_if;
  import mlcd_pkg::*;
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   x;
  logic [ByteW-1:0]   y;
  logic [ByteW-1:0]   width;
  logic [ByteW-1:0]   height;
  logic [ByteW-1:0]   data;

  modport source (output valid, action, x, y, width, height, data, input ready);
  modport sink   (input valid, action, x, y, width, height, data, output ready);
endinterface

interface mlcd_out_if;
  import mlcd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic             status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

>>> src/mlcd_byte_alu.sv
// Shared byte unit: modify one display byte by pixel mask, load or invert.
`timescale 1ns / 1ps
module mlcd_byte_alu (
  input  mlcd_pkg::alu_ctrl_t        ctrl_i,
  input  logic [mlcd_pkg::ByteW-1:0] old_i,
  output logic [mlcd_pkg::ByteW-1:0] new_o
);
  import mlcd_pkg::*;

  logic [ByteW-1:0] mask;

  assign mask = ByteW'(1) << ctrl_i.bit_idx;

  always_comb begin
    case (ctrl_i.op)
      ALU_SET:  new_o = old_i | mask;
      ALU_CLR:  new_o = old_i & ~mask;
      ALU_TGL:  new_o = old_i ^ mask;
      ALU_LOAD: new_o = ctrl_i.data;
      ALU_INV:  new_o = old_i ^ InvertMask;
      default:  new_o = old_i;
    endcase
  end

endmodule

>>> src/mono_lcd_page_framebuffer_engine_core.sv
// Sequence: pixel, byte write and read items pass through a read state, a write state and
// the done state; ignored items and empty inverts go straight to done, inverts read and
// write each clipped byte in turn, and fills write every byte of the memory before done.
// Throughput: one item at a time; ready returns once the result is loaded, later while the
// previous result still waits on the sink.
// Reset: clear the whole memory; accept no item until done.
`timescale 1ns / 1ps
module mono_lcd_page_framebuffer_engine_core #(
  parameter int SCREEN_COLUMNS = mlcd_pkg::ScreenColumns,
  parameter int SCREEN_PAGES   = mlcd_pkg::ScreenPages
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlcd_in_if.sink    in_i,
  mlcd_out_if.source out_o
);
  import mlcd_pkg::*;

  localparam int Depth = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(SCREEN_COLUMNS);
  localparam int PW    = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;

  // Range limits, widened to nine bits so that 8-bit fields plus extents compare cleanly
  localparam logic [8:0]    ColLimit  = 9'(SCREEN_COLUMNS);
  localparam logic [8:0]    RowLimit  = 9'(8 * SCREEN_PAGES);
  localparam logic [8:0]    PageLimit = 9'(SCREEN_PAGES);
  localparam logic [AW-1:0] ColsA     = AW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0] LastA     = AW'(Depth - 1);

  // Sequencer and walk state
  state_e           state_q, state_d;
  logic [AW-1:0]    sweep_q;
  logic [CW-1:0]    col_q, col_start_q;
  logic [PW-1:0]    page_q;
  logic [CW:0]      col_end_q;
  logic [PW:0]      page_end_q;
  alu_ctrl_t        ctrl_q;
  logic [ByteW-1:0] res_data_q;
  logic             res_status_q;

  // Result register
  logic             out_valid_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_status_q;

  // Display memory
  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rdata_q;
  logic [AW-1:0]    mem_addr;
  logic [ByteW-1:0] mem_wdata;
  logic             mem_we;

  logic             in_acc;
  logic             out_load;
  logic             sweep_last;
  logic             pix_ok, inv_ok, inv_empty, pix_action;
  logic [8:0]       sum_x, sum_y, col_end_w, page_end_w;
  logic [CW:0]      col_nx;
  logic [PW:0]      page_nx;
  logic             col_wrap, inv_last;
  logic [ByteW-1:0] alu_new;
  alu_op_e          op_w;
  logic             bad_w;
  action_e          act;

  assign act    = action_e'(in_i.action);
  assign in_acc = in_i.valid && in_i.ready;

  // Decode and range-check the incoming item
  assign pix_ok    = ({1'b0, in_i.x} < ColLimit) && ({1'b0, in_i.y} < RowLimit);
  assign inv_ok    = ({1'b0, in_i.x} < ColLimit) && ({1'b0, in_i.y} < PageLimit);
  assign inv_empty = (in_i.width == '0) || (in_i.height == '0);
  assign sum_x     = {1'b0, in_i.x} + {1'b0, in_i.width};
  assign sum_y     = {1'b0, in_i.y} + {1'b0, in_i.height};
  // Clip the rectangle at the right and bottom edges
  assign col_end_w  = (sum_x > ColLimit) ? ColLimit : sum_x;
  assign page_end_w = (sum_y > PageLimit) ? PageLimit : sum_y;

  always_comb begin
    pix_action = 1'b0;
    op_w       = ALU_KEEP;
    bad_w      = 1'b1;
    case (act)
      ACT_SET: begin
        pix_action = 1'b1;
        op_w       = ALU_SET;
        bad_w      = !pix_ok;
      end
      ACT_CLEAR: begin
        pix_action = 1'b1;
        op_w       = ALU_CLR;
        bad_w      = !pix_ok;
      end
      ACT_TOGGLE: begin
        pix_action = 1'b1;
        op_w       = ALU_TGL;
        bad_w      = !pix_ok;
      end
      ACT_WRITE: begin
        pix_action = 1'b1;
        op_w       = ALU_LOAD;
        bad_w      = !pix_ok;
      end
      ACT_READ: begin
        pix_action = 1'b1;
        op_w       = ALU_KEEP;
        bad_w      = !pix_ok;
      end
      ACT_INVERT: begin
        op_w  = ALU_INV;
        bad_w = !inv_ok;
      end
      ACT_FILL: begin
        bad_w = 1'b0;
      end
      default: begin
        bad_w = 1'b1;
      end
    endcase
  end

  // Rectangle walk: columns fastest, wrap to the start column at the clipped edge
  assign col_nx     = {1'b0, col_q} + 1'b1;
  assign page_nx    = {1'b0, page_q} + 1'b1;
  assign col_wrap   = (col_nx == col_end_q);
  assign inv_last   = col_wrap && (page_nx == page_end_q);
  assign sweep_last = (sweep_q == LastA);

  mlcd_byte_alu u_alu (
    .ctrl_i (ctrl_q),
    .old_i  (rdata_q),
    .new_o  (alu_new)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (bad_w) begin
            state_d = ST_DONE;
          end else if (pix_action) begin
            state_d = ST_PIX_RD;
          end else if (act == ACT_FILL) begin
            state_d = ST_FILL;
          end else if (inv_empty) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_INV_RD;
          end
        end
      end
      ST_PIX_RD: state_d = ST_PIX_WR;
      ST_PIX_WR: state_d = ST_DONE;
      ST_INV_RD: state_d = ST_INV_WR;
      ST_INV_WR: state_d = inv_last ? ST_DONE : ST_INV_RD;
      ST_FILL:   if (sweep_last) state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = alu_new;
    mem_addr  = AW'(page_q) * ColsA + AW'(col_q);
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        mem_addr  = sweep_q;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = ctrl_q.data;
        mem_addr  = sweep_q;
      end
      ST_PIX_WR: mem_we = 1'b1;
      ST_INV_WR: mem_we = 1'b1;
      default:   mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_CLEAR) || (state_q == ST_FILL)) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q        <= CW'(in_i.x);
      col_start_q  <= CW'(in_i.x);
      page_q       <= pix_action ? PW'(in_i.y[7:3]) : PW'(in_i.y);
      col_end_q    <= (CW+1)'(col_end_w);
      page_end_q   <= (PW+1)'(page_end_w);
      ctrl_q       <= '{op: op_w, bit_idx: in_i.y[2:0], data: in_i.data};
      res_data_q   <= '0;
      res_status_q <= bad_w;
    end
    if (state_q == ST_PIX_WR) res_data_q <= alu_new;
    if (state_q == ST_INV_WR) begin
      if (col_wrap) begin
        col_q  <= col_start_q;
        page_q <= page_nx[PW-1:0];
      end else begin
        col_q <= col_nx[CW-1:0];
      end
    end
    if (out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.status    = out_status_q;

endmodule

>>> src/mlcd_checker.sv
// Port-level checker for the page framebuffer engine, with its bind.
`timescale 1ns / 1ps
`include "mono_lcd_page_framebuffer_engine_core_defines.svh"
module mlcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_read_data_i,
  input logic       out_status_i
);

  `MLCD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `MLCD_ASSERT_STABLE(a_out_stable, out_valid_i && !out_ready_i, out_read_data_i)
  `MLCD_ASSERT(a_one_item, in_valid_i && in_ready_i |=> !in_ready_i)
  `MLCD_ASSERT(a_ignored_zero, out_valid_i && out_status_i |-> out_read_data_i == 8'h00)

endmodule

bind mono_lcd_page_framebuffer_engine_core mlcd_checker u_mlcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_data_i (out_o.read_data),
  .out_status_i    (out_o.status)
);

>>> sim/tb.sv
// Self-checking testbench for the page framebuffer engine: shadow memory, driver, checker.
`timescale 1ns / 1ps
module tb;
  import mlcd_pkg::*;

  // Action code 7 has no meaning and must be flagged as ignored.
  localparam logic [ActionW-1:0] ActUnused = 3'd7;
  localparam int FbBytes = ScreenColumns * ScreenPages;
  localparam int FbAW = $clog2(FbBytes);
  localparam int PixelRows = 8 * ScreenPages;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ByteW-1:0]   x;
    logic [ByteW-1:0]   y;
    logic [ByteW-1:0]   width;
    logic [ByteW-1:0]   height;
    logic [ByteW-1:0]   data;
  } lcd_cmd_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             status;
  } lcd_result_t;

  logic clk_i;
  logic rst_ni;

  mlcd_in_if  cmd_if ();
  mlcd_out_if res_if ();

  mono_lcd_page_framebuffer_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // Shadow copy of the display memory, page-major: page * columns + column.
  logic [ByteW-1:0] shadow_fb [FbBytes];
  lcd_result_t      due_results_q [$];

  int  errors;
  int  n_cmds;
  int  n_checked;
  int  n_fills;
  int  n_inverts;
  int  n_ignored;
  bit  no_idle;        // both sides run without gaps while set
  int  rx_hold_cycles; // one-off long stall requested of the result sink

  // Clock: 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Work out the result of one command and update the shadow memory with its effect.
  function automatic lcd_result_t apply_lcd_command(input lcd_cmd_t c);
    lcd_result_t      r;
    int               col;
    int               row;
    logic [FbAW-1:0]  addr;
    logic [ByteW-1:0] pix_mask;
    logic [ByteW-1:0] col_byte;
    r.read_data = '0;
    r.status    = 1'b0;
    col = int'(c.x);
    row = int'(c.y);
    case (c.action)
      ACT_SET, ACT_CLEAR, ACT_TOGGLE, ACT_WRITE, ACT_READ: begin
        if (col >= ScreenColumns || row >= PixelRows) begin
          r.status = 1'b1;
        end else begin
          addr     = FbAW'((row / 8) * ScreenColumns + col);
          pix_mask = 8'd1 << c.y[2:0];
          col_byte = shadow_fb[addr];
          case (c.action)
            ACT_SET:    col_byte = col_byte | pix_mask;
            ACT_CLEAR:  col_byte = col_byte & ~pix_mask;
            ACT_TOGGLE: col_byte = col_byte ^ pix_mask;
            ACT_WRITE:  col_byte = c.data;
            default: ;
          endcase
          shadow_fb[addr] = col_byte;
          r.read_data     = col_byte;
        end
      end
      ACT_INVERT: begin
        // For invert, y is a page; the rectangle is clipped at right and bottom.
        if (col >= ScreenColumns || row >= ScreenPages) begin
          r.status = 1'b1;
        end else begin
          for (int j = 0; j < int'(c.height) && row + j < ScreenPages; j++) begin
            for (int i = 0; i < int'(c.width) && col + i < ScreenColumns; i++) begin
              addr = FbAW'((row + j) * ScreenColumns + col + i);
              shadow_fb[addr] = shadow_fb[addr] ^ InvertMask;
            end
          end
        end
      end
      ACT_FILL: begin
        foreach (shadow_fb[k]) shadow_fb[k] = c.data;
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic lcd_cmd_t mk_cmd(input logic [ActionW-1:0] action,
                                      input logic [ByteW-1:0] x, input logic [ByteW-1:0] y,
                                      input logic [ByteW-1:0] w, input logic [ByteW-1:0] h,
                                      input logic [ByteW-1:0] d);
    lcd_cmd_t c;
    c.action = action;
    c.x      = x;
    c.y      = y;
    c.width  = w;
    c.height = h;
    c.data   = d;
    return c;
  endfunction

  // Random command: mostly valid pixel and byte traffic on a small hot region so that
  // reads hit earlier writes, some clipped inverts, rare fills, and a share of rubbish.
  function automatic lcd_cmd_t random_lcd_command();
    lcd_cmd_t c;
    int       pick;
    c.x      = ByteW'($urandom_range(0, 255));
    c.y      = ByteW'($urandom_range(0, 255));
    c.width  = ByteW'($urandom_range(0, 255));
    c.height = ByteW'($urandom_range(0, 255));
    c.data   = ByteW'($urandom_range(0, 255));
    pick     = $urandom_range(0, 99);
    if (pick < 80) begin
      if      (pick < 18) c.action = ACT_SET;
      else if (pick < 30) c.action = ACT_CLEAR;
      else if (pick < 42) c.action = ACT_TOGGLE;
      else if (pick < 58) c.action = ACT_WRITE;
      else                c.action = ACT_READ;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          c.x = ByteW'($urandom_range(0, 7));
          c.y = ByteW'($urandom_range(0, 15));
        end
        5, 6, 7, 8: begin
          c.x = ByteW'($urandom_range(0, ScreenColumns - 1));
          c.y = ByteW'($urandom_range(0, PixelRows - 1));
        end
        default: ; // keep full-range position, mostly out of range
      endcase
    end else if (pick < 92) begin
      c.action = ACT_INVERT;
      if ($urandom_range(0, 9) != 0) c.x = ByteW'($urandom_range(0, ScreenColumns - 1));
      if ($urandom_range(0, 9) != 0) c.y = ByteW'($urandom_range(0, ScreenPages - 1));
      // Keep most rectangles small: a large one walks the whole memory.
      if ($urandom_range(0, 15) != 0) begin
        c.width  = ByteW'($urandom_range(0, 10));
        c.height = ByteW'($urandom_range(0, 3));
      end
    end else if (pick < 94) begin
      c.action = ACT_FILL;
    end else begin
      c.action = ActUnused;
    end
    return c;
  endfunction

  // Offer one command, hold it until taken, then record what must come back.
  task automatic send_lcd_command(input lcd_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.action <= c.action;
    cmd_if.x      <= c.x;
    cmd_if.y      <= c.y;
    cmd_if.width  <= c.width;
    cmd_if.height <= c.height;
    cmd_if.data   <= c.data;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    due_results_q.push_back(apply_lcd_command(c));
    n_cmds++;
    if (c.action == ACT_FILL)   n_fills++;
    if (c.action == ACT_INVERT) n_inverts++;
  endtask

  // Edge positions, every action, out-of-range cases, clipping and fill.
  task automatic test_directed_cases();
    send_lcd_command(mk_cmd(ACT_SET,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_SET,    8'd127, 8'd63,  8'd255, 8'd255, 8'd255));
    send_lcd_command(mk_cmd(ACT_SET,    8'd127, 8'd62,  8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_TOGGLE, 8'd127, 8'd63,  8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_CLEAR,  8'd127, 8'd62,  8'd0,   8'd0,   8'd0));
    // half boundary: column 64 is the first of the right half
    send_lcd_command(mk_cmd(ACT_WRITE,  8'd64,  8'd8,   8'd0,   8'd0,   8'hFF));
    send_lcd_command(mk_cmd(ACT_CLEAR,  8'd64,  8'd15,  8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_READ,   8'd64,  8'd9,   8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_WRITE,  8'd63,  8'd7,   8'd0,   8'd0,   8'h00));
    send_lcd_command(mk_cmd(ACT_READ,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
    // out-of-range positions are ignored and flagged
    send_lcd_command(mk_cmd(ACT_SET,    8'd128, 8'd0,   8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_CLEAR,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_TOGGLE, 8'd0,   8'd64,  8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_WRITE,  8'd5,   8'd255, 8'd0,   8'd0,   8'hAA));
    send_lcd_command(mk_cmd(ACT_READ,   8'd200, 8'd200, 8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ActUnused,  8'd1,   8'd1,   8'd1,   8'd1,   8'd1));
    // inverts: empty, bad origin, clipped, whole screen
    send_lcd_command(mk_cmd(ACT_INVERT, 8'd10,  8'd2,   8'd0,   8'd3,   8'd0));
    send_lcd_command(mk_cmd(ACT_INVERT, 8'd10,  8'd2,   8'd5,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_INVERT, 8'd128, 8'd0,   8'd4,   8'd1,   8'd0));
    send_lcd_command(mk_cmd(ACT_INVERT, 8'd0,   8'd8,   8'd4,   8'd1,   8'd0));
    send_lcd_command(mk_cmd(ACT_INVERT, 8'd120, 8'd6,   8'd20,  8'd5,   8'd0));
    send_lcd_command(mk_cmd(ACT_READ,   8'd125, 8'd48,  8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_INVERT, 8'd0,   8'd0,   8'd255, 8'd255, 8'd0));
    send_lcd_command(mk_cmd(ACT_READ,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_FILL,   8'd0,   8'd0,   8'd0,   8'd0,   8'hA5));
    send_lcd_command(mk_cmd(ACT_READ,   8'd127, 8'd63,  8'd0,   8'd0,   8'd0));
    send_lcd_command(mk_cmd(ACT_FILL,   8'd0,   8'd0,   8'd0,   8'd0,   8'h00));
  endtask

  // Random traffic with random gaps, broken up by stretches of back-to-back items.
  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      no_idle = (i % 128) >= 100;
      send_lcd_command(random_lcd_command());
    end
    no_idle = 1'b0;
  endtask

  // Stall the result side for a long stretch while commands keep coming.
  task automatic test_result_backpressure();
    no_idle        = 1'b1;
    rx_hold_cycles = 300;
    repeat (24) send_lcd_command(random_lcd_command());
    no_idle = 1'b0;
  endtask

  // Full-rate traffic on both sides.
  task automatic test_back_to_back(input int n);
    no_idle = 1'b1;
    repeat (n) send_lcd_command(random_lcd_command());
    no_idle = 1'b0;
  endtask

  // Result sink: random stalls per item, or a one-off long hold when requested.
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  // Compare every accepted result with the oldest one still due.
  always @(posedge clk_i) begin : result_check
    lcd_result_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (due_results_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due: read_data %02h status %0d",
                 $time, res_if.read_data, res_if.status);
      end else begin
        want = due_results_q.pop_front();
        n_checked++;
        if (want.status) n_ignored++;
        if (res_if.read_data !== want.read_data) begin
          errors++;
          $display("%0t: read_data mismatch: expected %02h, got %02h",
                   $time, want.read_data, res_if.read_data);
        end
        if (res_if.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, res_if.status);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.action  = '0;
    cmd_if.x       = '0;
    cmd_if.y       = '0;
    cmd_if.width   = '0;
    cmd_if.height  = '0;
    cmd_if.data    = '0;
    errors         = 0;
    n_cmds         = 0;
    n_checked      = 0;
    n_fills        = 0;
    n_inverts      = 0;
    n_ignored      = 0;
    no_idle        = 1'b0;
    rx_hold_cycles = 0;
    foreach (shadow_fb[k]) shadow_fb[k] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing pass after reset shows up as ready held low on the first item

    test_directed_cases();
    test_random_traffic(600);
    test_result_backpressure();
    test_back_to_back(100);

    cmd_if.valid <= 1'b0;
    while (due_results_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Sent %0d commands and checked %0d results (%0d flagged as ignored),",
             n_cmds, n_checked, n_ignored);
    $display("including %0d rectangle inverts and %0d whole-memory fills.",
             n_inverts, n_fills);
    if (errors == 0) begin
      $display("** mono_lcd_page_framebuffer_engine_core: PASSED **");
    end else begin
      $display("** mono_lcd_page_framebuffer_engine_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("%0t: timeout with %0d results still due", $time, due_results_q.size());
    $display("** mono_lcd_page_framebuffer_engine_core: FAILED **");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/mlcd_pkg.sv
src/mlcd_chan_if.sv
src/mlcd_byte_alu.sv
src/mono_lcd_page_framebuffer_engine_core.sv
src/mlcd_checker.sv
sim/tb.sv
